FILE: rtl/core/tcw_pkg.sv
// Shared types, constants and helpers for the text console writer.
`default_nettype none

package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;

   localparam int CELLS   = COLUMNS * ROWS;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int CNT_W   = $clog2(CELLS + 1);
   localparam int LIN_W   = 11;
   localparam int POS_W   = (ADDR_W > LIN_W) ? ADDR_W : LIN_W;
   localparam int SCROLL_LAST = CELLS - COLUMNS;

   localparam int OP_W    = 2;
   localparam int CHAR_W  = 8;
   localparam int ATTR_W  = 8;
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int CELL_W  = 16;

   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
   localparam logic [ATTR_W-1:0] INIT_ATTR    = 8'h07;
   localparam logic [COL_W:0]    TAB_STEP     = (COL_W + 1)'(8);
   localparam logic [COL_W:0]    TAB_MASK     = ~((COL_W + 1)'(7));

   typedef enum logic [OP_W-1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_SET   = 2'd2,
      OP_READ  = 2'd3
   } tcw_op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL,
      ST_FILL,
      ST_DONE
   } tcw_state_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [CELL_W-1:0] data;
   } tcw_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } tcw_rd_type;

   typedef struct packed {
      logic              valid;
      logic [COL_W-1:0]  cursor_col;
      logic [ROW_W-1:0]  cursor_row;
      logic [LIN_W-1:0]  cursor_linear;
      logic [CELL_W-1:0] cell_data;
   } tcw_result_type;

   function automatic logic [POS_W-1:0] cell_pos(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
      return POS_W'(r) * POS_W'(COLUMNS) + POS_W'(c);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tcw_req_if.sv
// Request channel interface of the text console writer.
`default_nettype none

interface tcw_req_if;
   logic                        valid;
   logic                        ready;
   logic [tcw_pkg::OP_W-1:0]    req_type;
   logic [tcw_pkg::CHAR_W-1:0]  char_code;
   logic [tcw_pkg::ATTR_W-1:0]  color;
   logic [tcw_pkg::COL_W-1:0]   col;
   logic [tcw_pkg::ROW_W-1:0]   row;

   modport source (output valid, output req_type, output char_code, output color,
                   output col, output row, input ready);
   modport sink   (input valid, input req_type, input char_code, input color,
                   input col, input row, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tcw_rsp_if.sv
// Response channel interface of the text console writer.
`default_nettype none

interface tcw_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tcw_pkg::COL_W-1:0]   cursor_col;
   logic [tcw_pkg::ROW_W-1:0]   cursor_row;
   logic [tcw_pkg::LIN_W-1:0]   cursor_linear;
   logic [tcw_pkg::CELL_W-1:0]  cell_data;

   modport source (output valid, output cursor_col, output cursor_row,
                   output cursor_linear, output cell_data, input ready);
   modport sink   (input valid, input cursor_col, input cursor_row,
                   input cursor_linear, input cell_data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tcw_cell_ram.sv
// Character cell store: one write port and one registered read port.
`default_nettype none

module tcw_cell_ram (
   input  wire logic                      clock,
   input  wire tcw_pkg::tcw_wr_type       wr,
   input  wire tcw_pkg::tcw_rd_type       rd,
   output logic [tcw_pkg::CELL_W-1:0]     rd_data
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] mem [CELLS];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/tcw_seq.sv
// Sequencer: cursor, request decode and the clear, scroll and fill sweeps.
`default_nettype none

module tcw_seq (
   input  wire logic                      clock,
   input  wire logic                      reset,
   tcw_req_if.sink                        req_chan,
   input  wire logic                      rsp_free,
   input  wire logic [tcw_pkg::CELL_W-1:0] rd_data,
   output tcw_pkg::tcw_wr_type            wr,
   output tcw_pkg::tcw_rd_type            rd,
   output tcw_pkg::tcw_result_type        result
);
   import tcw_pkg::*;

   tcw_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   tcw_op_type        op_ff;
   logic [CHAR_W-1:0] char_ff;
   logic [ATTR_W-1:0] attr_ff;
   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;
   logic              accept;
   logic              scroll_needed;
   logic [COL_W:0]    col_step;
   logic [ROW_W:0]    row_step;
   logic              wrap;
   logic [COL_W-1:0]  addr_col;
   logic [ROW_W-1:0]  addr_row;
   logic [POS_W-1:0]  pos;
   logic [POS_W-1:0]  cur_pos;
   logic [CNT_W-1:0]  idx_rd;
   logic [CNT_W-1:0]  idx_wr;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign pos            = cell_pos(addr_row, addr_col);
   assign cur_pos        = cell_pos(cur_row_ff, cur_col_ff);
   assign idx_rd         = idx_ff + CNT_W'(COLUMNS);
   assign idx_wr         = idx_ff - CNT_W'(1);
   assign row_step       = {1'b0, cur_row_ff} + (ROW_W + 1)'(1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (idx_ff == CNT_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (op_ff)
               OP_PUT:   state_in = scroll_needed ? ST_SCROLL : ST_DONE;
               OP_CLEAR: state_in = ST_FILL;
               default:  state_in = ST_DONE;
            endcase
         end
         ST_SCROLL: begin
            if (idx_ff == CNT_W'(SCROLL_LAST)) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (idx_ff == CNT_W'(CELLS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      idx_in        = idx_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      scroll_needed = 1'b0;
      col_step      = '0;
      wrap          = 1'b0;
      addr_col      = cur_col_ff;
      addr_row      = cur_row_ff;
      wr.en         = 1'b0;
      wr.addr       = pos[ADDR_W-1:0];
      wr.data       = {attr_ff, BLANK_CHAR};
      rd.en         = 1'b0;
      rd.addr       = pos[ADDR_W-1:0];
      result.valid         = (state_ff == ST_DONE);
      result.cursor_col    = cur_col_ff;
      result.cursor_row    = cur_row_ff;
      result.cursor_linear = cur_pos[LIN_W-1:0];
      result.cell_data     = (op_ff == OP_READ) ? rd_data : '0;
      case (state_ff)
         ST_INIT: begin
            wr.en   = 1'b1;
            wr.addr = idx_ff[ADDR_W-1:0];
            wr.data = {INIT_ATTR, BLANK_CHAR};
            idx_in  = idx_ff + CNT_W'(1);
         end
         ST_EXEC: begin
            idx_in = '0;
            case (op_ff)
               OP_PUT: begin
                  if (char_ff == CH_NEWLINE) begin
                     wrap = 1'b1;
                  end else if (char_ff == CH_RETURN) begin
                     cur_col_in = '0;
                  end else if (char_ff == CH_TAB) begin
                     col_step = ({1'b0, cur_col_ff} + TAB_STEP) & TAB_MASK;
                     if (col_step >= (COL_W + 1)'(COLUMNS)) begin
                        wrap = 1'b1;
                     end else begin
                        cur_col_in = col_step[COL_W-1:0];
                     end
                  end else if (char_ff == CH_BACKSPACE) begin
                     if (cur_col_ff != '0) begin
                        cur_col_in = cur_col_ff - COL_W'(1);
                     end else if (cur_row_ff != '0) begin
                        cur_row_in = cur_row_ff - ROW_W'(1);
                        cur_col_in = COL_W'(COLUMNS - 1);
                     end
                     addr_col = cur_col_in;
                     addr_row = cur_row_in;
                     wr.en    = 1'b1;
                  end else begin
                     wr.en    = 1'b1;
                     wr.data  = {attr_ff, char_ff};
                     col_step = {1'b0, cur_col_ff} + (COL_W + 1)'(1);
                     if (col_step >= (COL_W + 1)'(COLUMNS)) begin
                        wrap = 1'b1;
                     end else begin
                        cur_col_in = col_step[COL_W-1:0];
                     end
                  end
                  if (wrap) begin
                     cur_col_in = '0;
                     if (row_step >= (ROW_W + 1)'(ROWS)) begin
                        cur_row_in    = ROW_W'(ROWS - 1);
                        scroll_needed = 1'b1;
                     end else begin
                        cur_row_in = row_step[ROW_W-1:0];
                     end
                  end
               end
               OP_CLEAR: begin
                  cur_col_in = '0;
                  cur_row_in = '0;
               end
               OP_SET: begin
                  cur_col_in = col_ff;
                  cur_row_in = row_ff;
               end
               default: begin
                  addr_col = col_ff;
                  addr_row = row_ff;
                  rd.en    = 1'b1;
               end
            endcase
         end
         ST_SCROLL: begin
            rd.en   = (idx_ff != CNT_W'(SCROLL_LAST));
            rd.addr = idx_rd[ADDR_W-1:0];
            wr.en   = (idx_ff != '0);
            wr.addr = idx_wr[ADDR_W-1:0];
            wr.data = rd_data;
            if (idx_ff != CNT_W'(SCROLL_LAST)) begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_FILL: begin
            wr.en   = 1'b1;
            wr.addr = idx_ff[ADDR_W-1:0];
            idx_in  = idx_ff + CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_INIT;
         idx_ff     <= '0;
         cur_col_ff <= '0;
         cur_row_ff <= '0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= tcw_op_type'(req_chan.req_type);
         char_ff <= req_chan.char_code;
         attr_ff <= req_chan.color;
         col_ff  <= (req_chan.col > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : req_chan.col;
         row_ff  <= (req_chan.row > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : req_chan.row;
      end
   end

   a_no_same_cell: assert property (@(posedge clock) disable iff (reset)
      !(wr.en && rd.en && (wr.addr == rd.addr)))
      else $error("cell read and write collide");

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted transaction not executed");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (cur_col_ff <= COL_W'(COLUMNS - 1)) && (cur_row_ff <= ROW_W'(ROWS - 1)))
      else $error("cursor outside the screen");

   a_done_once: assert property (@(posedge clock) disable iff (reset)
      (result.valid && rsp_free) |=> (state_ff == ST_IDLE))
      else $error("result delivered more than once");

endmodule

`default_nettype wire

FILE: rtl/core/text_console_writer_unit.sv
// Top level of the text console writer: sequencer, cell store and response register.
//
//   Channel   Direction  Handshake      Contents
//   req_chan  in         valid/ready    req_type, char_code, color, col, row
//   rsp_chan  out        valid/ready    cursor_col, cursor_row, cursor_linear, cell_data
//
// After reset a clearing pass writes every cell to a grey blank, with req_chan.ready low.
// A set, read or plain put request passes from acceptance through ST_EXEC and ST_DONE;
// the response register loads as the sequencer returns to ST_IDLE for the next request.
// A scroll adds a sweep that moves each row up by one, then blanks the last row, and a
// clear blanks every cell, one cell per cycle through the single write port.
// The response register lets a request be accepted while the last response waits.
`default_nettype none

module text_console_writer_unit (
   input  wire logic clock,
   input  wire logic reset,
   tcw_req_if.sink   req_chan,
   tcw_rsp_if.source rsp_chan
);
   import tcw_pkg::*;

   tcw_wr_type        wr;
   tcw_rd_type        rd;
   tcw_result_type    result;
   logic [CELL_W-1:0] rd_data;
   logic              rsp_free;
   logic              rsp_valid_ff;
   tcw_result_type    rsp_data_ff;

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   tcw_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_free (rsp_free),
      .rd_data  (rd_data),
      .wr       (wr),
      .rd       (rd),
      .result   (result)
   );

   tcw_cell_ram u_cell_ram (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free && result.valid) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.cursor_col    = rsp_data_ff.cursor_col;
   assign rsp_chan.cursor_row    = rsp_data_ff.cursor_row;
   assign rsp_chan.cursor_linear = rsp_data_ff.cursor_linear;
   assign rsp_chan.cell_data     = rsp_data_ff.cell_data;

endmodule

`default_nettype wire
